// File: sv/srms_pkg.sv
// Shared constants and types for the sliding-window RMS block.
// Used by every module of the block; depends on nothing.
package srms_pkg;

  localparam int SAMPLE_BITS   = 12;
  localparam int WINDOW_MAX    = 4096;
  localparam int ACC_BITS      = 48;
  localparam int SQ_BITS       = 2 * SAMPLE_BITS;
  localparam int WIN_BITS      = 13;
  localparam int VPC_BITS      = 32;
  localparam int COUNTS_BITS   = 20;
  localparam int VOLTS_BITS    = 28;
  localparam int PROD_BITS     = COUNTS_BITS + VPC_BITS;
  localparam int DIV_BITS      = 64;
  localparam int FRAC_BITS     = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);

  localparam logic [WIN_BITS-1:0]    OFFSET_RESET = '0;
  localparam logic [WIN_BITS-1:0]    WINDOW_RESET = WIN_BITS'(1);
  localparam logic [VPC_BITS-1:0]    VPC_RESET    = 32'h8000_0000;
  localparam logic [COUNTS_BITS-1:0] COUNTS_MAX   = '1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SAMPLE_OFFSET   = 2'd0,
    REG_WINDOW_LENGTH   = 2'd1,
    REG_VOLTS_PER_COUNT = 2'd2
  } cfg_reg_t;

  // One queued job: the updated accumulator split into its sign bit and its lower bits.
  typedef struct packed {
    logic                neg;
    logic [ACC_BITS-2:0] mag;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: sv/sliding_window_rms_top.sv
// Top level of the sliding-window RMS block: configuration registers and the
// front end, job queue and back end. Depends on srms_pkg, srms_front, srms_queue, srms_back.
//
// Usage:
//   Input channel (in_valid / in_stall): one transaction carries the newest ADC
//   sample and the sample from one window earlier. The front end squares both
//   deviations from the DC offset, registers the squares and then updates a
//   48-bit running sum; it takes no new transaction while the last one is being
//   squared, and none while the two-entry job queue is full.
//   Output channel (out_valid / out_stall): one transaction per input, carrying
//   the RMS in counts (Q12.8), in volts (Q12.16) and the negative-sum flag.
//   The back end sets the pace and works on one job at a time: it takes a job,
//   runs a two-bit-per-cycle divider and a one-bit-per-cycle square root,
//   multiplies and then loads the output register.
//   A negative sum skips the arithmetic and goes straight to the output load.
//   Configuration (cfg_valid / cfg_ready): cfg_ready is always high; writes are
//   meant for idle periods. Unknown indices are ignored.
//   Reset (rst_n low, synchronous) clears the running sum, empties the queue,
//   drops out_valid and restores register defaults.
//   While out_stall is high the output holds; the back end finishes the next job
//   and waits, then the queue fills and in_stall rises.
module sliding_window_rms_top
  import srms_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [SAMPLE_BITS-1:0]   in_newest_sample,
  input  logic [SAMPLE_BITS-1:0]   in_oldest_sample,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [VOLTS_BITS-1:0]    out_rms_volts_q16,
  output logic [COUNTS_BITS-1:0]   out_rms_counts_q8,
  output logic                     out_sum_negative,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  logic [SAMPLE_BITS-1:0] sample_offset_r;
  logic [WIN_BITS-1:0]    window_length_r;
  logic [VPC_BITS-1:0]    vpc_r;

  q_push_t q_push;
  q_item_t q_head;
  q_stat_t q_stat;
  logic    q_pop;

  // The register file never pushes back.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_offset_r <= OFFSET_RESET[SAMPLE_BITS-1:0];
      window_length_r <= WINDOW_RESET;
      vpc_r           <= VPC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SAMPLE_OFFSET:   sample_offset_r <= cfg_data[SAMPLE_BITS-1:0];
        REG_WINDOW_LENGTH:   window_length_r <= cfg_data[WIN_BITS-1:0];
        REG_VOLTS_PER_COUNT: vpc_r           <= cfg_data[VPC_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // The front end owns the running sum; each accepted sample becomes one queued job.
  srms_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_newest_sample (in_newest_sample),
    .in_oldest_sample (in_oldest_sample),
    .sample_offset    (sample_offset_r),
    .q_stat           (q_stat),
    .q_push           (q_push)
  );

  srms_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_pop  (q_pop),
    .q_head (q_head),
    .q_stat (q_stat)
  );

  // The back end turns the sum into RMS values and drives the output register.
  srms_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_head              (q_head),
    .q_stat              (q_stat),
    .q_pop               (q_pop),
    .window_length       (window_length_r),
    .volts_per_count_q32 (vpc_r),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_rms_volts_q16   (out_rms_volts_q16),
    .out_rms_counts_q8   (out_rms_counts_q8),
    .out_sum_negative    (out_sum_negative)
  );

endmodule

// File: sv/srms_front.sv
// Front end: accepts samples, squares their deviations and updates the accumulator.
// Depends on srms_pkg; feeds srms_queue.
module srms_front
  import srms_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_newest_sample,
  input  logic [SAMPLE_BITS-1:0] in_oldest_sample,
  input  logic [SAMPLE_BITS-1:0] sample_offset,
  input  q_stat_t                q_stat,
  output q_push_t                q_push
);

  function automatic logic [SQ_BITS-1:0] dev_square(input logic [SAMPLE_BITS-1:0] s,
                                                    input logic [SAMPLE_BITS-1:0] ofs);
    logic [SAMPLE_BITS-1:0] d;
    d = (s >= ofs) ? (s - ofs) : (ofs - s);
    return SQ_BITS'(d) * SQ_BITS'(d);
  endfunction

  logic                sq_valid_r;
  logic [SQ_BITS-1:0]  sq_new_r;
  logic [SQ_BITS-1:0]  sq_old_r;
  logic [ACC_BITS-1:0] sum_r;
  logic [ACC_BITS-1:0] sum_nxt;
  logic                accept;

  // One transaction at a time; the queue always has room for the pending push.
  assign in_stall = sq_valid_r | q_stat.full;
  assign accept   = in_valid & ~in_stall;
  assign sum_nxt  = sum_r + ACC_BITS'(sq_new_r) - ACC_BITS'(sq_old_r);

  assign q_push.valid    = sq_valid_r;
  assign q_push.item.neg = sum_nxt[ACC_BITS-1];
  assign q_push.item.mag = sum_nxt[ACC_BITS-2:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_valid_r <= 1'b0;
      sum_r      <= '0;
    end else begin
      sq_valid_r <= accept;
      if (sq_valid_r) begin
        sum_r <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sq_new_r <= dev_square(in_newest_sample, sample_offset);
      sq_old_r <= dev_square(in_oldest_sample, sample_offset);
    end
  end

endmodule

// File: sv/srms_queue.sv
// Short job queue between the front end and the arithmetic back end.
// Depends on srms_pkg.
module srms_queue
  import srms_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  q_push_t q_push,
  input  logic    q_pop,
  output q_item_t q_head,
  output q_stat_t q_stat
);

  q_item_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r;
  logic [QPTR_BITS-1:0] rd_ptr_r;
  logic [QPTR_BITS:0]   count_r;

  function automatic logic [QPTR_BITS-1:0] ptr_inc(input logic [QPTR_BITS-1:0] p);
    return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign q_head       = mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (q_push.valid) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (q_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      count_r <= count_r + (QPTR_BITS+1)'(q_push.valid) - (QPTR_BITS+1)'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (q_push.valid) begin
      mem_r[wr_ptr_r] <= q_push.item;
    end
  end

endmodule

// File: sv/srms_back.sv
// Back end: serial divide by the window, serial square root, volts scaling, output register.
// Depends on srms_pkg; takes jobs from srms_queue.
module srms_back
  import srms_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  q_item_t                q_head,
  input  q_stat_t                q_stat,
  output logic                   q_pop,
  input  logic [WIN_BITS-1:0]    window_length,
  input  logic [VPC_BITS-1:0]    volts_per_count_q32,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [VOLTS_BITS-1:0]  out_rms_volts_q16,
  output logic [COUNTS_BITS-1:0] out_rms_counts_q8,
  output logic                   out_sum_negative
);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_DIV  = 5'b00010,
    B_SQRT = 5'b00100,
    B_MUL  = 5'b01000,
    B_DONE = 5'b10000
  } back_state_t;

  localparam int STEP_BITS   = $clog2(DIV_BITS / 2);
  localparam int VOLT_SHIFT  = PROD_BITS - VOLTS_BITS;

  back_state_t            state_r, state_nxt;
  logic [STEP_BITS-1:0]   cnt_r, cnt_nxt;
  logic [DIV_BITS-1:0]    dq_r, dq_nxt;
  logic [WIN_BITS-1:0]    rem_r, rem_nxt;
  logic [DIV_BITS-1:0]    v_r, v_nxt;
  logic [DIV_BITS-1:0]    res_r, res_nxt;
  logic [DIV_BITS-1:0]    bit_r, bit_nxt;
  logic [COUNTS_BITS-1:0] counts_r, counts_nxt;
  logic [PROD_BITS-1:0]   prod_r, prod_nxt;
  logic                   neg_r, neg_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [VOLTS_BITS-1:0]  volts_r, volts_nxt;
  logic [COUNTS_BITS-1:0] ocounts_r, ocounts_nxt;
  logic                   oneg_r, oneg_nxt;
  logic [WIN_BITS-1:0]    n_eff;

  // A zero window acts as one, anything above the maximum as the maximum.
  always_comb begin
    priority if (window_length == '0) begin
      n_eff = WIN_BITS'(1);
    end else if (window_length > WIN_BITS'(WINDOW_MAX)) begin
      n_eff = WIN_BITS'(WINDOW_MAX);
    end else begin
      n_eff = window_length;
    end
  end

  always_comb begin
    logic [WIN_BITS-1:0] r_tmp;
    logic [DIV_BITS-1:0] d_tmp;
    logic [DIV_BITS-1:0] t_sum;
    logic [DIV_BITS-1:0] res_tmp;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    v_nxt         = v_r;
    res_nxt       = res_r;
    bit_nxt       = bit_r;
    counts_nxt    = counts_r;
    prod_nxt      = prod_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r;
    volts_nxt     = volts_r;
    ocounts_nxt   = ocounts_r;
    oneg_nxt      = oneg_r;
    q_pop         = 1'b0;
    r_tmp         = rem_r;
    d_tmp         = dq_r;
    t_sum         = res_r + bit_r;
    res_tmp       = res_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          q_pop   = 1'b1;
          neg_nxt = q_head.neg;
          if (q_head.neg) begin
            counts_nxt = '0;
            prod_nxt   = '0;
            state_nxt  = B_DONE;
          end else begin
            dq_nxt    = {1'b0, q_head.mag, {FRAC_BITS{1'b0}}};
            rem_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = B_DIV;
          end
        end
      end
      B_DIV: begin
        // Two restoring division steps per cycle; quotient bits shift in from the bottom.
        for (int i = 0; i < 2; i++) begin
          r_tmp = {r_tmp[WIN_BITS-2:0], d_tmp[DIV_BITS-1]};
          d_tmp = {d_tmp[DIV_BITS-2:0], 1'b0};
          if (r_tmp >= n_eff) begin
            r_tmp    = r_tmp - n_eff;
            d_tmp[0] = 1'b1;
          end
        end
        dq_nxt  = d_tmp;
        rem_nxt = r_tmp;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == '1) begin
          v_nxt     = d_tmp;
          res_nxt   = '0;
          bit_nxt   = DIV_BITS'(1) << (DIV_BITS - 2);
          cnt_nxt   = '0;
          state_nxt = B_SQRT;
        end
      end
      B_SQRT: begin
        if (v_r >= t_sum) begin
          v_nxt   = v_r - t_sum;
          res_tmp = (res_r >> 1) + bit_r;
        end else begin
          res_tmp = res_r >> 1;
        end
        res_nxt = res_tmp;
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == '1) begin
          counts_nxt = (|res_tmp[DIV_BITS-1:COUNTS_BITS]) ? COUNTS_MAX
                                                          : res_tmp[COUNTS_BITS-1:0];
          state_nxt  = B_MUL;
        end
      end
      B_MUL: begin
        prod_nxt  = PROD_BITS'(counts_r) * PROD_BITS'(volts_per_count_q32);
        state_nxt = B_DONE;
      end
      B_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          volts_nxt     = prod_r[PROD_BITS-1:VOLT_SHIFT];
          ocounts_nxt   = counts_r;
          oneg_nxt      = neg_r;
          state_nxt     = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    dq_r      <= dq_nxt;
    rem_r     <= rem_nxt;
    v_r       <= v_nxt;
    res_r     <= res_nxt;
    bit_r     <= bit_nxt;
    counts_r  <= counts_nxt;
    prod_r    <= prod_nxt;
    neg_r     <= neg_nxt;
    volts_r   <= volts_nxt;
    ocounts_r <= ocounts_nxt;
    oneg_r    <= oneg_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_rms_volts_q16 = volts_r;
  assign out_rms_counts_q8 = ocounts_r;
  assign out_sum_negative  = oneg_r;

endmodule

// File: sv/srms_checker.sv
// Port-level checks for the sliding-window RMS block, bound to its top level.
// Depends on srms_pkg and sliding_window_rms_top.
module srms_checker
  import srms_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [VOLTS_BITS-1:0]    out_rms_volts_q16,
  input logic [COUNTS_BITS-1:0]   out_rms_counts_q8,
  input logic                     out_sum_negative
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rms_volts_q16)
      && $stable(out_rms_counts_q8) && $stable(out_sum_negative))
    else $error("stalled result changed");

  // A clamped result carries zero values.
  a_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sum_negative |-> out_rms_volts_q16 == '0 && out_rms_counts_q8 == '0)
    else $error("negative sum not clamped");

  // Volts are a scaled copy of counts, so zero counts give zero volts.
  a_zero_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rms_counts_q8 == '0 |-> out_rms_volts_q16 == '0)
    else $error("volts nonzero for zero counts");

  // The front end is busy for the cycle after each accepted transaction.
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("front end accepted back to back");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sliding_window_rms_top srms_checker u_srms_checker (.*);

// File: tb/tb_sliding_window_rms_top.sv
// Self-checking testbench for sliding_window_rms_top: drives sample pairs and register
// writes, predicts every RMS result and compares it field by field.
// Depends on srms_pkg and the RTL of the block only.
module tb_sliding_window_rms_top;
  timeunit 1ns;
  timeprecision 1ps;
  import srms_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int PHASE_ITEMS  = 120;
  localparam int NUM_PHASES   = 8;
  localparam int LONG_HOLD    = 900;
  localparam int MAX_WAIT     = 14;
  localparam int TAIL_CYCLES  = 150;
  localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;

  // Index 3 is not a register; writes to it must leave the settings alone.
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

  localparam logic [63:0] COUNTS_SAT = 64'((64'd1 << COUNTS_BITS) - 1);
  localparam logic [63:0] VOLTS_SAT  = 64'((64'd1 << VOLTS_BITS) - 1);
  // Above this the random stream pulls the running sum back down.
  localparam logic [ACC_BITS-1:0] ACC_CEILING = ACC_BITS'(64'd1 << 32);

  typedef struct packed {
    logic [VOLTS_BITS-1:0]  volts;
    logic [COUNTS_BITS-1:0] counts;
    logic                   neg;
  } rms_result_t;

  // Holds a private copy of the running sum and the three registers, works out the
  // RMS of every accepted sample pair and checks the results in order.
  class rms_checker;
    logic [ACC_BITS-1:0]    acc;
    logic [SAMPLE_BITS-1:0] offset;
    logic [WIN_BITS-1:0]    win;
    logic [VPC_BITS-1:0]    vpc;
    rms_result_t            pending_rms[$];
    int errors;
    int n_inputs;
    int n_checked;
    int n_negative;
    int n_saturated;

    function new();
      acc         = '0;
      offset      = SAMPLE_BITS'(OFFSET_RESET);
      win         = WINDOW_RESET;
      vpc         = VPC_RESET;
      errors      = 0;
      n_inputs    = 0;
      n_checked   = 0;
      n_negative  = 0;
      n_saturated = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_SAMPLE_OFFSET:   offset = data[SAMPLE_BITS-1:0];
        REG_WINDOW_LENGTH:   win = data[WIN_BITS-1:0];
        REG_VOLTS_PER_COUNT: vpc = data[VPC_BITS-1:0];
        default: ;
      endcase
    endfunction

    function logic [SQ_BITS-1:0] dev_square(logic [SAMPLE_BITS-1:0] s);
      logic [SQ_BITS-1:0] d;
      d = (s >= offset) ? SQ_BITS'(s - offset) : SQ_BITS'(offset - s);
      return d * d;
    endfunction

    function logic [63:0] floor_sqrt(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = '0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v   = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // Updates the running sum with one sample pair and queues the expected RMS.
    function void note_input(logic [SAMPLE_BITS-1:0] newest, logic [SAMPLE_BITS-1:0] oldest);
      rms_result_t r;
      logic [63:0] mean;
      logic [63:0] root;
      logic [63:0] scaled;
      logic [WIN_BITS-1:0] n;
      n_inputs++;
      acc = acc + ACC_BITS'(dev_square(newest)) - ACC_BITS'(dev_square(oldest));
      if (acc[ACC_BITS-1]) begin
        r.volts  = '0;
        r.counts = '0;
        r.neg    = 1'b1;
        n_negative++;
      end else begin
        n = win;
        if (n == 0) n = 1;
        if (n > WINDOW_MAX) n = WIN_BITS'(WINDOW_MAX);
        mean = (64'(acc) << FRAC_BITS) / 64'(n);
        root = floor_sqrt(mean);
        if (root > COUNTS_SAT) begin
          root = COUNTS_SAT;
          n_saturated++;
        end
        scaled = (root * 64'(vpc)) >> 24;
        if (scaled > VOLTS_SAT) scaled = VOLTS_SAT;
        r.volts  = scaled[VOLTS_BITS-1:0];
        r.counts = root[COUNTS_BITS-1:0];
        r.neg    = 1'b0;
      end
      pending_rms.push_back(r);
    endfunction

    task report(string msg);
      if (errors < 100) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [VOLTS_BITS-1:0] volts, logic [COUNTS_BITS-1:0] counts,
                      logic neg);
      rms_result_t want;
      n_checked++;
      if (pending_rms.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", n_checked));
      end else begin
        want = pending_rms.pop_front();
        if (volts !== want.volts)
          report($sformatf("result %0d rms_volts_q16 %0h, expected %0h",
                           n_checked, volts, want.volts));
        if (counts !== want.counts)
          report($sformatf("result %0d rms_counts_q8 %0h, expected %0h",
                           n_checked, counts, want.counts));
        if (neg !== want.neg)
          report($sformatf("result %0d sum_negative %b, expected %b",
                           n_checked, neg, want.neg));
      end
    endtask
  endclass

  // Every input of the block starts at a known value; reset is held from time zero.
  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [SAMPLE_BITS-1:0]   in_newest_sample = '0;
  logic [SAMPLE_BITS-1:0]   in_oldest_sample = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [VOLTS_BITS-1:0]    out_rms_volts_q16;
  logic [COUNTS_BITS-1:0]   out_rms_counts_q8;
  logic                     out_sum_negative;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  rms_checker sb = new();

  // When idle_on is low both sides run without gaps. hold_reqs is bumped by the
  // stimulus to ask the result side for one long hold-off.
  bit idle_on = 1'b1;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int rx_wait;
  int settings_used = 1;

  sliding_window_rms_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_newest_sample  (in_newest_sample),
    .in_oldest_sample  (in_oldest_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_rms_volts_q16 (out_rms_volts_q16),
    .out_rms_counts_q8 (out_rms_counts_q8),
    .out_sum_negative  (out_sum_negative),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Result side. Every value is sampled at the rising edge before the block's own
  // updates land, so a transaction counts exactly when out_valid was high and
  // out_stall low going into the edge. After each transaction the receiver draws
  // how long it will stall; a hold-off request overrides that with a long stall,
  // counted here, which lets the block back up until in_stall rises.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall)
        sb.check_result(out_rms_volts_q16, out_rms_counts_q8, out_sum_negative);
      if (hold_seen != hold_reqs) begin
        hold_seen <= hold_reqs;
        hold_left <= LONG_HOLD;
        out_stall <= 1'b1;
      end else if (out_valid && !out_stall) begin
        rx_wait = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (rx_wait > 0) begin
          out_stall <= 1'b1;
          hold_left <= rx_wait;
        end
      end else if (hold_left > 1) begin
        hold_left <= hold_left - 1;
      end else if (hold_left == 1) begin
        hold_left <= 0;
        out_stall <= 1'b0;
      end
    end
  end

  // Offers one sample pair after a random gap and holds it until the block takes it.
  // A pair that follows with no gap is put up in the same step as the acceptance, so
  // in_valid simply stays high; it is lowered only when a gap or a pause follows.
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] newest,
                             input logic [SAMPLE_BITS-1:0] oldest);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_newest_sample <= newest;
    in_oldest_sample <= oldest;
    do @(posedge clk); while (in_stall);
    sb.note_input(newest, oldest);
  endtask

  // Stops offering and waits until every expected result has been taken. It always
  // waits on the clock before it returns, so the next assignment to in_valid lands in a later step.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_rms.size() != 0);
  endtask

  // One register write; the idle cycle after it keeps back-to-back writes apart.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Samples cluster on the rails, near the DC offset, or anywhere in range.
  function automatic logic [SAMPLE_BITS-1:0] pick_sample(input logic [SAMPLE_BITS-1:0] center);
    int v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = SAMPLE_MAX;
      2, 3: v = int'(center) + int'($urandom_range(0, 64)) - 32;
      default: v = int'($urandom_range(0, SAMPLE_MAX));
    endcase
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return SAMPLE_BITS'(v);
  endfunction

  // One random phase: new register settings, then a stream in which the oldest sample
  // is the newest one from depth items back, as a real window would deliver it. About
  // one item in ten is a broken pair with no relation to the history. The stream also
  // steers the running sum: a negative sum is pulled up by skipping a removal, and a
  // very large one is pulled down by a quiet sample against a rail. At the end the
  // window is flushed with quiet samples so that the next offset starts clean.
  task automatic run_phase(input int ph);
    logic [SAMPLE_BITS-1:0] history[$];
    logic [SAMPLE_BITS-1:0] off;
    logic [SAMPLE_BITS-1:0] newest;
    logic [SAMPLE_BITS-1:0] oldest;
    logic [WIN_BITS-1:0]    win;
    logic [VPC_BITS-1:0]    vpc;
    int depth;
    off = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
    win = WIN_BITS'($urandom_range(1, (1 << WIN_BITS) - 1));
    vpc = $urandom;
    case (ph)
      0: begin
        off = '0;
        win = WIN_BITS'(1);
        vpc = '1;
      end
      1: begin
        off = '1;
        win = WIN_BITS'(WINDOW_MAX);
        vpc = '0;
      end
      2: win = '0;
      3: begin
        off = SAMPLE_BITS'(1 << (SAMPLE_BITS - 1));
        win = WIN_BITS'($urandom_range(1, 64));
        vpc = VPC_RESET;
      end
      4: win = '1;
      6: begin
        win = WIN_BITS'($urandom_range(1, 16));
        vpc = '1;
      end
      7: begin
        off = '0;
        win = WIN_BITS'($urandom_range(1, WINDOW_MAX));
      end
      default: ;
    endcase

    // Registers change only with nothing in flight. The upper data bits are random
    // so that the block is seen to drop them.
    wait_drained();
    write_reg(REG_SAMPLE_OFFSET, ($urandom & ~32'hFFF) | 32'(off));
    write_reg(REG_WINDOW_LENGTH, ($urandom & ~32'h1FFF) | 32'(win));
    write_reg(REG_VOLTS_PER_COUNT, vpc);
    if (ph == 2 || ph == 5) write_reg(REG_UNUSED, $urandom);
    settings_used++;

    // Three phases run flat out on both sides; the hold-off phase keeps the sender busy.
    idle_on = !(ph == 2 || ph == 3 || ph == 5);
    depth = (ph == 0) ? 16 : $urandom_range(1, 16);

    for (int k = 0; k < PHASE_ITEMS; k++) begin
      if (ph == 3 && k == 10) hold_reqs <= hold_reqs + 1;
      if (ph == 4 && k == PHASE_ITEMS / 2) wait_drained();
      newest = pick_sample(off);
      if ($urandom_range(0, 9) == 0) begin
        oldest = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
      end else begin
        oldest = (history.size() == depth) ? history.pop_front() : off;
        if (sb.acc[ACC_BITS-1]) begin
          oldest = off;
        end else if (sb.acc > ACC_CEILING) begin
          newest = off;
          oldest = off[SAMPLE_BITS-1] ? '0 : '1;
        end
        history.push_back(newest);
      end
      send_sample(newest, oldest);
    end
    while (history.size() != 0) send_sample(off, history.pop_front());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, first with the reset settings: a full-scale step up, a second one
    // that saturates the counts output, the way back down and one step past zero so
    // the sum goes negative and the outputs clamp.
    send_sample(12'd0, 12'd0);
    send_sample(12'd4095, 12'd0);
    send_sample(12'd4095, 12'd0);
    send_sample(12'd0, 12'd4095);
    send_sample(12'd0, 12'd4095);
    send_sample(12'd0, 12'd4095);
    send_sample(12'd4095, 12'd0);

    // Offset at full scale with the upper data bits set, a zero window length that
    // must act as one, and the largest volts-per-count scale.
    wait_drained();
    write_reg(REG_SAMPLE_OFFSET, 32'hFFFF_FFFF);
    write_reg(REG_WINDOW_LENGTH, 32'hFFFF_E000);
    write_reg(REG_VOLTS_PER_COUNT, 32'hFFFF_FFFF);
    settings_used++;
    send_sample(12'd0, 12'd4095);
    send_sample(12'd4095, 12'd4095);
    send_sample(12'd2048, 12'd0);
    send_sample(12'd0, 12'd2048);

    // Mid-scale offset, the largest window and a zero scale.
    wait_drained();
    write_reg(REG_SAMPLE_OFFSET, 32'h1234_5800);
    write_reg(REG_WINDOW_LENGTH, 32'(WINDOW_MAX));
    write_reg(REG_VOLTS_PER_COUNT, 32'h0);
    settings_used++;
    send_sample(12'd4095, 12'd2048);
    send_sample(12'd0, 12'd2048);
    send_sample(12'd2048, 12'd4095);
    send_sample(12'd1, 12'd1);

    // A window length beyond the limit, a write to the unused index, the smallest
    // nonzero scale.
    wait_drained();
    write_reg(REG_WINDOW_LENGTH, 32'hFFFF_FFFF);
    write_reg(REG_UNUSED, $urandom);
    write_reg(REG_VOLTS_PER_COUNT, 32'h1);
    settings_used++;
    send_sample(12'd4095, 12'd0);
    send_sample(12'd4095, 12'd0);
    send_sample(12'd0, 12'd4095);
    send_sample(12'd2730, 12'd1365);
    send_sample(12'd0, 12'd0);

    for (int ph = 0; ph < NUM_PHASES; ph++) run_phase(ph);

    // Let everything drain, then give the block time to show any stray result.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending_rms.size() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending_rms.size()));

    $display("summary: %0d sample pairs under %0d register settings, %0d results checked",
             sb.n_inputs, settings_used, sb.n_checked);
    $display("summary: %0d results clamped on a negative sum, %0d with saturated counts",
             sb.n_negative, sb.n_saturated);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: a run that has not finished by now is stuck.
  initial begin
    #(2 * CLK_HALF * LIMIT_CYCLES);
    $display("tb: failure");
    $finish;
  end

endmodule
